[rtl/wps_pkg.sv]
// ----------------------------------------------------------------------------
// Weld pulse sequencer package
// Shared widths, types, codes and default gap length of the weld pulse sequencer.
// ----------------------------------------------------------------------------
package wps_pkg;

  localparam int unsigned CUR_W     = 16;
  localparam int unsigned VOLT_W    = 16;
  localparam int unsigned ELAPSED_W = 10;
  localparam int unsigned SINCE_W   = 16;
  localparam int unsigned STABLE_W  = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  localparam int unsigned GAP_TICKS_DEF = 60;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PRE  = 2'd1,
    PH_GAP  = 2'd2,
    PH_MAIN = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_START        = 3'd1,
    EV_END          = 3'd2,
    EV_OVERCURRENT  = 3'd3,
    EV_UNDERVOLTAGE = 3'd4
  } event_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_CUR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_V  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_CUR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STABLE_N  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_LEN   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_LEN  = 3'd7;

  typedef struct packed {
    logic                 auto_en;
    logic                 guard_on;
    logic [CUR_W-1:0]     trigger_current;
    logic [VOLT_W-1:0]    cutoff_voltage;
    logic [CUR_W-1:0]     limit_current;
    logic [SINCE_W-1:0]   cooldown_ticks;
    logic [STABLE_W-1:0]  stable_windows_needed;
    logic [ELAPSED_W-1:0] pre_pulse_ticks;
    logic [ELAPSED_W-1:0] main_pulse_ticks;
  } cfg_t;

  typedef struct packed {
    logic              manual_start;
    logic              window_done;
    logic [CUR_W-1:0]  rms_current;
    logic [VOLT_W-1:0] rms_voltage;
  } item_t;

  typedef struct packed {
    logic   switch_on;
    phase_t weld_phase;
    event_t event_code;
    logic   ready_res;
  } result_t;

endpackage

[rtl/wps_cfg.sv]
// ----------------------------------------------------------------------------
// Weld pulse sequencer configuration registers
// Write-only register file holding thresholds, timings and enables.
// ----------------------------------------------------------------------------
module wps_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [wps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wps_pkg::CFG_DAT_W-1:0]  cfg_data,
  output wps_pkg::cfg_t                  cfg
);
  import wps_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.auto_en               <= 1'b0;
      cfg.guard_on              <= 1'b0;
      cfg.trigger_current       <= '0;
      cfg.cutoff_voltage        <= '0;
      cfg.limit_current         <= '1;
      cfg.cooldown_ticks        <= SINCE_W'(1000);
      cfg.stable_windows_needed <= STABLE_W'(3);
      cfg.pre_pulse_ticks       <= ELAPSED_W'(30);
      cfg.main_pulse_ticks      <= ELAPSED_W'(100);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE: begin
          cfg.auto_en  <= cfg_data[0];
          cfg.guard_on <= cfg_data[1];
        end
        REG_TRIG_CUR:  cfg.trigger_current       <= cfg_data[CUR_W-1:0];
        REG_CUTOFF_V:  cfg.cutoff_voltage        <= cfg_data[VOLT_W-1:0];
        REG_LIMIT_CUR: cfg.limit_current         <= cfg_data[CUR_W-1:0];
        REG_COOLDOWN:  cfg.cooldown_ticks        <= cfg_data[SINCE_W-1:0];
        REG_STABLE_N:  cfg.stable_windows_needed <= cfg_data[STABLE_W-1:0];
        REG_PRE_LEN:   cfg.pre_pulse_ticks       <= cfg_data[ELAPSED_W-1:0];
        REG_MAIN_LEN:  cfg.main_pulse_ticks      <= cfg_data[ELAPSED_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/wps_core.sv]
// ----------------------------------------------------------------------------
// Weld pulse sequencer core
// Input register, sequencer state and the per-tick update logic.
// ----------------------------------------------------------------------------
module wps_core #(
  parameter int unsigned GAP_TICKS = wps_pkg::GAP_TICKS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  wps_pkg::cfg_t    cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  wps_pkg::item_t   in_item,
  input  logic             res_free,
  output logic             res_load,
  output wps_pkg::result_t res
);
  import wps_pkg::*;

  localparam logic [ELAPSED_W-1:0] GapLen = ELAPSED_W'(GAP_TICKS);

  // Input register.
  logic  ivalid;
  item_t item;

  // Sequencer state.
  phase_t               phase_reg, phase_next;
  logic [ELAPSED_W-1:0] phase_elapsed, phase_elapsed_next;
  logic [SINCE_W-1:0]   since_weld_end, since_weld_end_next;
  logic [STABLE_W-1:0]  stable_count, stable_count_next;
  logic [CUR_W-1:0]     held_current, held_current_next;
  logic [VOLT_W-1:0]    held_voltage, held_voltage_next;

  logic                 advance;
  logic [SINCE_W-1:0]   since_inc;
  logic [STABLE_W-1:0]  stable_upd;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic [ELAPSED_W-1:0] phase_len;
  logic                 over_cur, under_volt, abort, ready, start, phase_done;
  event_t               event_code;

  assign advance  = ivalid && res_free;
  assign in_ready = !ivalid || advance;
  assign res_load = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ivalid <= 1'b0;
    end else if (in_ready) begin
      ivalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

  // Window latch and stable window count.
  always_comb begin
    since_inc = (since_weld_end == '1) ? since_weld_end : since_weld_end + 1'b1;
    held_current_next = held_current;
    held_voltage_next = held_voltage;
    stable_upd        = stable_count;
    if (item.window_done) begin
      held_current_next = item.rms_current;
      held_voltage_next = item.rms_voltage;
      if (item.rms_current >= cfg.trigger_current &&
          item.rms_voltage >= cfg.cutoff_voltage) begin
        stable_upd = (stable_count == '1) ? stable_count : stable_count + 1'b1;
      end else begin
        stable_upd = '0;
      end
    end
  end

  always_comb begin
    over_cur    = held_current_next > cfg.limit_current;
    under_volt  = held_voltage_next < cfg.cutoff_voltage;
    abort       = cfg.guard_on && (phase_reg != PH_IDLE) && (over_cur || under_volt);
    ready       = (phase_reg == PH_IDLE) && cfg.auto_en &&
                  !(cfg.guard_on && under_volt) &&
                  (since_inc >= cfg.cooldown_ticks) &&
                  (stable_upd >= cfg.stable_windows_needed);
    start       = (phase_reg == PH_IDLE) && (ready || item.manual_start);
    elapsed_inc = (phase_elapsed == '1) ? phase_elapsed : phase_elapsed + 1'b1;
    unique case (phase_reg)
      PH_PRE:  phase_len = cfg.pre_pulse_ticks;
      PH_GAP:  phase_len = GapLen;
      default: phase_len = cfg.main_pulse_ticks;
    endcase
    phase_done = elapsed_inc >= phase_len;
  end

  // Next state.
  always_comb begin
    phase_next          = phase_reg;
    phase_elapsed_next  = phase_elapsed;
    since_weld_end_next = since_inc;
    stable_count_next   = ready ? '0 : stable_upd;
    if (abort) begin
      phase_next          = PH_IDLE;
      phase_elapsed_next  = '0;
      since_weld_end_next = '0;
    end else begin
      unique case (phase_reg)
        PH_IDLE: begin
          if (start) begin
            phase_next         = (cfg.pre_pulse_ticks != '0) ? PH_PRE : PH_MAIN;
            phase_elapsed_next = '0;
          end
        end
        PH_PRE: begin
          phase_elapsed_next = phase_done ? '0 : elapsed_inc;
          if (phase_done) begin
            phase_next = PH_GAP;
          end
        end
        PH_GAP: begin
          phase_elapsed_next = phase_done ? '0 : elapsed_inc;
          if (phase_done) begin
            phase_next = PH_MAIN;
          end
        end
        PH_MAIN: begin
          phase_elapsed_next = phase_done ? '0 : elapsed_inc;
          if (phase_done) begin
            phase_next          = PH_IDLE;
            since_weld_end_next = '0;
          end
        end
      endcase
    end
  end

  // Outputs of the tick.
  always_comb begin
    priority if (abort) begin
      event_code = over_cur ? EV_OVERCURRENT : EV_UNDERVOLTAGE;
    end else if (start) begin
      event_code = EV_START;
    end else if (phase_reg == PH_MAIN && phase_done) begin
      event_code = EV_END;
    end else begin
      event_code = EV_NONE;
    end
    res.switch_on  = (phase_next == PH_PRE) || (phase_next == PH_MAIN);
    res.weld_phase = phase_next;
    res.event_code = event_code;
    res.ready_res  = ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg      <= PH_IDLE;
      phase_elapsed  <= '0;
      since_weld_end <= '0;
      stable_count   <= '0;
      held_current   <= '0;
      held_voltage   <= '0;
    end else if (advance) begin
      phase_reg      <= phase_next;
      phase_elapsed  <= phase_elapsed_next;
      since_weld_end <= since_weld_end_next;
      stable_count   <= stable_count_next;
      held_current   <= held_current_next;
      held_voltage   <= held_voltage_next;
    end
  end

endmodule

[rtl/wps_outreg.sv]
// ----------------------------------------------------------------------------
// Weld pulse sequencer result register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module wps_outreg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  wps_pkg::result_t res_in,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output wps_pkg::result_t res_out
);
  import wps_pkg::*;

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

[rtl/weld_pulse_sequencer.sv]
// ----------------------------------------------------------------------------
// Weld pulse sequencer
// Four-phase weld sequencer with auto arming, cooldown and current/voltage
// guard, advanced by one millisecond tick per input word.
// ----------------------------------------------------------------------------
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+---------------------------------------------
//  input    | in_valid / in_ready   | manual_start, window_done, rms_current,
//           |                       | rms_voltage
//  output   | out_valid / out_ready | switch_on, weld_phase, event_code, ready_res
//  config   | cfg_we                | cfg_index, cfg_data
//
//  An accepted word waits in the input register until the result register
//  is free, and its result word is then loaded there. One word per cycle is
//  sustained while out_ready keeps up. Reset is synchronous and returns the
//  sequencer to idle with default configuration. When out_ready holds the
//  result register, in_ready drops once the input register holds a word too.
// ----------------------------------------------------------------------------
module weld_pulse_sequencer #(
  parameter int unsigned GAP_TICKS = wps_pkg::GAP_TICKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          manual_start,
  input  logic                          window_done,
  input  logic [wps_pkg::CUR_W-1:0]     rms_current,
  input  logic [wps_pkg::VOLT_W-1:0]    rms_voltage,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          switch_on,
  output logic [1:0]                    weld_phase,
  output logic [2:0]                    event_code,
  output logic                          ready_res,
  input  logic                          cfg_we,
  input  logic [wps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wps_pkg::CFG_DAT_W-1:0] cfg_data
);
  import wps_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  result_t res, res_out;
  logic    res_free, res_load;

  assign in_item.manual_start = manual_start;
  assign in_item.window_done  = window_done;
  assign in_item.rms_current  = rms_current;
  assign in_item.rms_voltage  = rms_voltage;

  wps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  wps_core #(
    .GAP_TICKS (GAP_TICKS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .res_free (res_free),
    .res_load (res_load),
    .res      (res)
  );

  wps_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_load),
    .res_in    (res),
    .free      (res_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_out)
  );

  assign switch_on  = res_out.switch_on;
  assign weld_phase = res_out.weld_phase;
  assign event_code = res_out.event_code;
  assign ready_res  = res_out.ready_res;

endmodule

[rtl/wps_checker.sv]
// ----------------------------------------------------------------------------
// Weld pulse sequencer port checker
// Watches the top-level ports for result consistency and handshake rules.
// ----------------------------------------------------------------------------
module wps_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       switch_on,
  input logic [1:0] weld_phase,
  input logic [2:0] event_code,
  input logic       ready_res
);
  import wps_pkg::*;

  // The relay drive follows the phase of the same word.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (switch_on == ((weld_phase == PH_PRE) || (weld_phase == PH_MAIN))))
    else $error("switch_on does not match weld_phase");

  // A start leaves the sequencer running; an end or abort leaves it idle.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_code == EV_START) |-> (weld_phase != PH_IDLE))
    else $error("weld start reported with idle phase");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && ((event_code == EV_END) || (event_code == EV_OVERCURRENT) ||
                  (event_code == EV_UNDERVOLTAGE)) |-> (weld_phase == PH_IDLE))
    else $error("weld end or abort reported with running phase");

  // An auto trigger always starts a weld in the same tick.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && ready_res |-> (event_code == EV_START))
    else $error("ready without weld start");

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(switch_on) &&
      $stable(weld_phase) && $stable(event_code) && $stable(ready_res))
    else $error("result word changed while stalled");

endmodule

bind weld_pulse_sequencer wps_checker u_wps_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .switch_on  (switch_on),
  .weld_phase (weld_phase),
  .event_code (event_code),
  .ready_res  (ready_res)
);

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Weld pulse sequencer testbench
// Drives millisecond tick words into the sequencer with random gaps. It applies
// random back pressure on the result side. Every result word is checked
// against a behavioral model of the weld phases, the guard, the cooldown and
// the stable window count. Directed cases come first, then long pulses, then
// counter saturation, and last random weld traffic under several settings.
// ----------------------------------------------------------------------------
module testbench;
  import wps_pkg::*;

  localparam logic [ELAPSED_W-1:0] GAP_LEN = ELAPSED_W'(GAP_TICKS_DEF);

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 manual_start = 1'b0;
  logic                 window_done = 1'b0;
  logic [CUR_W-1:0]     rms_current = '0;
  logic [VOLT_W-1:0]    rms_voltage = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 switch_on;
  logic [1:0]           weld_phase;
  logic [2:0]           event_code;
  logic                 ready_res;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;

  weld_pulse_sequencer u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .manual_start(manual_start), .window_done(window_done),
    .rms_current(rms_current), .rms_voltage(rms_voltage),
    .out_valid(out_valid), .out_ready(out_ready),
    .switch_on(switch_on), .weld_phase(weld_phase),
    .event_code(event_code), .ready_res(ready_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Behavioral copy of the sequencer state and its registers.
  cfg_t                 sim_cfg;
  phase_t               sim_phase;
  logic [ELAPSED_W-1:0] sim_elapsed;
  logic [SINCE_W-1:0]   sim_since_end;
  logic [STABLE_W-1:0]  sim_stable;
  logic [CUR_W-1:0]     sim_held_cur;
  logic [VOLT_W-1:0]    sim_held_volt;

  result_t     expected_ticks[$];
  int unsigned faults = 0;
  bit          gap_mode = 1'b1;
  bit          stall_mode = 1'b1;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic result_t advance_tick(input item_t t);
    result_t              r;
    event_t               ev;
    logic                 rdy;
    logic [ELAPSED_W-1:0] len;
    ev  = EV_NONE;
    rdy = 1'b0;
    if (sim_since_end != '1) sim_since_end++;
    if (t.window_done) begin
      sim_held_cur  = t.rms_current;
      sim_held_volt = t.rms_voltage;
      if (t.rms_current >= sim_cfg.trigger_current &&
          t.rms_voltage >= sim_cfg.cutoff_voltage) begin
        if (sim_stable != '1) sim_stable++;
      end else begin
        sim_stable = '0;
      end
    end
    if (sim_cfg.guard_on && sim_phase != PH_IDLE &&
        (sim_held_cur > sim_cfg.limit_current || sim_held_volt < sim_cfg.cutoff_voltage)) begin
      // Overcurrent wins when both limits are violated.
      ev = (sim_held_cur > sim_cfg.limit_current) ? EV_OVERCURRENT : EV_UNDERVOLTAGE;
      sim_phase     = PH_IDLE;
      sim_elapsed   = '0;
      sim_since_end = '0;
    end else if (sim_phase == PH_IDLE) begin
      rdy = sim_cfg.auto_en &&
            !(sim_cfg.guard_on && sim_held_volt < sim_cfg.cutoff_voltage) &&
            sim_since_end >= sim_cfg.cooldown_ticks &&
            sim_stable >= sim_cfg.stable_windows_needed;
      if (rdy) sim_stable = '0;
      if (rdy || t.manual_start) begin
        sim_phase   = (sim_cfg.pre_pulse_ticks != '0) ? PH_PRE : PH_MAIN;
        sim_elapsed = '0;
        ev          = EV_START;
      end
    end else begin
      if (sim_elapsed != '1) sim_elapsed++;
      case (sim_phase)
        PH_PRE:  len = sim_cfg.pre_pulse_ticks;
        PH_GAP:  len = GAP_LEN;
        default: len = sim_cfg.main_pulse_ticks;
      endcase
      if (sim_elapsed >= len) begin
        sim_elapsed = '0;
        case (sim_phase)
          PH_PRE:  sim_phase = PH_GAP;
          PH_GAP:  sim_phase = PH_MAIN;
          default: begin
            sim_phase     = PH_IDLE;
            sim_since_end = '0;
            ev            = EV_END;
          end
        endcase
      end
    end
    r.switch_on  = (sim_phase == PH_PRE || sim_phase == PH_MAIN);
    r.weld_phase = sim_phase;
    r.event_code = ev;
    r.ready_res  = rdy;
    return r;
  endfunction

  function automatic item_t tick_of(input logic m, input logic w,
                                    input logic [CUR_W-1:0] c, input logic [VOLT_W-1:0] v);
    item_t t;
    t.manual_start = m;
    t.window_done  = w;
    t.rms_current  = c;
    t.rms_voltage  = v;
    return t;
  endfunction

  // A value a little below to well above a threshold, so compares go both ways.
  function automatic logic [15:0] near_value(input logic [15:0] center);
    int v;
    v = int'(center) + int'($urandom_range(0, 48)) - 8;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  function automatic item_t random_tick();
    item_t t;
    t.manual_start = ($urandom_range(0, 24) == 0);
    t.window_done  = ($urandom_range(0, 2) == 0);
    case ($urandom_range(0, 4))
      0, 1, 2: t.rms_current = near_value(sim_cfg.trigger_current);
      3:       t.rms_current = near_value(sim_cfg.limit_current);
      default: t.rms_current = 16'($urandom_range(0, 65535));
    endcase
    if ($urandom_range(0, 3) != 0) t.rms_voltage = near_value(sim_cfg.cutoff_voltage);
    else t.rms_voltage = 16'($urandom_range(0, 65535));
    return t;
  endfunction

  task automatic send_tick(input item_t t);
    int unsigned gap;
    gap = gap_mode ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    manual_start = t.manual_start;
    window_done  = t.window_done;
    rms_current  = t.rms_current;
    rms_voltage  = t.rms_voltage;
    in_valid     = 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_ticks.push_back(advance_tick(t));
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Registers change only with the pipeline empty.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    drain;
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_ENABLE: begin
        sim_cfg.auto_en  = val[0];
        sim_cfg.guard_on = val[1];
      end
      REG_TRIG_CUR:  sim_cfg.trigger_current = val;
      REG_CUTOFF_V:  sim_cfg.cutoff_voltage = val;
      REG_LIMIT_CUR: sim_cfg.limit_current = val;
      REG_COOLDOWN:  sim_cfg.cooldown_ticks = val;
      REG_STABLE_N:  sim_cfg.stable_windows_needed = val[STABLE_W-1:0];
      REG_PRE_LEN:   sim_cfg.pre_pulse_ticks = val[ELAPSED_W-1:0];
      REG_MAIN_LEN:  sim_cfg.main_pulse_ticks = val[ELAPSED_W-1:0];
      default: ;
    endcase
  endtask

  task automatic test_reset_values;
    send_tick(tick_of(1'b0, 1'b0, 16'h0000, 16'h0000));
    send_tick(tick_of(1'b0, 1'b1, 16'hFFFF, 16'hFFFF));
    send_tick(tick_of(1'b0, 1'b1, 16'h0000, 16'h0000));
  endtask

  task automatic test_guard_and_start_cases;
    write_reg(REG_ENABLE, 16'd3);
    write_reg(REG_TRIG_CUR, 16'd100);
    write_reg(REG_CUTOFF_V, 16'd200);
    write_reg(REG_LIMIT_CUR, 16'd1000);
    write_reg(REG_COOLDOWN, 16'd0);
    write_reg(REG_STABLE_N, 16'd2);
    write_reg(REG_PRE_LEN, 16'd0);
    write_reg(REG_MAIN_LEN, 16'd2);
    // The first good window fires the auto trigger, then a manual start mid pulse.
    send_tick(tick_of(1'b0, 1'b1, 16'd500, 16'd300));
    send_tick(tick_of(1'b0, 1'b1, 16'd500, 16'd300));
    send_tick(tick_of(1'b1, 1'b0, 16'hFFFF, 16'h0000));
    send_tick(tick_of(1'b0, 1'b0, 16'd0, 16'd0));
    // Held current above the limit aborts on the next tick with no new window.
    send_tick(tick_of(1'b1, 1'b1, 16'd2000, 16'd300));
    send_tick(tick_of(1'b0, 1'b0, 16'd0, 16'hFFFF));
    // Both limits violated: the overcurrent abort takes priority.
    send_tick(tick_of(1'b1, 1'b1, 16'd2000, 16'd100));
    send_tick(tick_of(1'b0, 1'b0, 16'd0, 16'd0));
    send_tick(tick_of(1'b1, 1'b1, 16'd50, 16'd100));
    send_tick(tick_of(1'b0, 1'b0, 16'd0, 16'd0));
    send_tick(tick_of(1'b0, 1'b1, 16'd500, 16'd300));
    // A zero-length main pulse ends on the first tick after it starts.
    write_reg(REG_MAIN_LEN, 16'd0);
    send_tick(tick_of(1'b1, 1'b1, 16'd50, 16'd300));
    send_tick(tick_of(1'b0, 1'b0, 16'd0, 16'd0));
    send_tick(tick_of(1'b1, 1'b1, 16'hFFFF, 16'hFFFF));
    send_tick(tick_of(1'b0, 1'b0, 16'd0, 16'd0));
  endtask

  task automatic test_long_pulses;
    item_t t;
    write_reg(REG_ENABLE, 16'd1);
    write_reg(REG_TRIG_CUR, 16'hFFFF);
    write_reg(REG_CUTOFF_V, 16'hFFFF);
    write_reg(REG_LIMIT_CUR, 16'd0);
    write_reg(REG_STABLE_N, 16'd1);
    write_reg(REG_PRE_LEN, 16'd60);
    write_reg(REG_MAIN_LEN, 16'd100);
    for (int i = 0; i < 230; i++) begin
      t = random_tick();
      t.manual_start = (i == 0);
      t.window_done  = t.window_done && ($urandom_range(0, 3) == 0);
      send_tick(t);
    end
    write_reg(REG_ENABLE, 16'd3);
    send_tick(tick_of(1'b1, 1'b1, 16'd1, 16'hFFFF));
    send_tick(tick_of(1'b0, 1'b0, 16'd0, 16'd0));
  endtask

  // Runs long enough for the stable window count to saturate.
  task automatic test_counter_saturation;
    item_t t;
    write_reg(REG_ENABLE, 16'd0);
    write_reg(REG_TRIG_CUR, 16'd0);
    write_reg(REG_CUTOFF_V, 16'd0);
    write_reg(REG_LIMIT_CUR, 16'hFFFF);
    write_reg(REG_COOLDOWN, 16'd200);
    write_reg(REG_STABLE_N, 16'd255);
    write_reg(REG_PRE_LEN, 16'd0);
    write_reg(REG_MAIN_LEN, 16'd1);
    gap_mode   = 1'b0;
    stall_mode = 1'b0;
    for (int i = 0; i < 280; i++) begin
      t = random_tick();
      t.manual_start = 1'b0;
      t.window_done  = 1'b1;
      send_tick(t);
    end
    write_reg(REG_ENABLE, 16'd1);
    repeat (4) send_tick(tick_of(1'b0, 1'b0, 16'd0, 16'd0));
    gap_mode   = 1'b1;
    stall_mode = 1'b1;
  endtask

  task automatic test_random_welds;
    int unsigned trig;
    int unsigned lim;
    for (int p = 0; p < 5; p++) begin
      trig = $urandom_range(0, 3000);
      lim  = trig + $urandom_range(0, 60);
      write_reg(REG_ENABLE, (p < 4) ? 16'(p) : 16'($urandom_range(0, 3)));
      write_reg(REG_TRIG_CUR, 16'(trig));
      write_reg(REG_CUTOFF_V, 16'($urandom_range(0, 3000)));
      write_reg(REG_LIMIT_CUR, 16'(lim));
      write_reg(REG_COOLDOWN, 16'($urandom_range(0, 30)));
      write_reg(REG_STABLE_N, 16'($urandom_range(0, 3)));
      write_reg(REG_PRE_LEN, ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 5)));
      write_reg(REG_MAIN_LEN, 16'($urandom_range(0, 10)));
      for (int n = 0; n < 60; n++) begin
        if (n % 20 == 0) begin
          gap_mode   = ($urandom_range(0, 2) != 0);
          stall_mode = ($urandom_range(0, 2) != 0);
        end
        // Let the pipeline run dry once per setting.
        if (n == 30) drain;
        send_tick(random_tick());
      end
    end
  endtask

  initial begin
    int unsigned hold;
    wait (!rst);
    @(negedge clk);
    forever begin
      hold = stall_mode ? $urandom_range(0, 4) : 0;
      if (hold != 0) begin
        out_ready = 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_ticks.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("%0t: unexpected result word sw=%0b ph=%0d ev=%0d rdy=%0b",
                   $time, switch_on, weld_phase, event_code, ready_res);
      end else begin
        want = expected_ticks.pop_front();
        if (switch_on !== want.switch_on || weld_phase !== want.weld_phase ||
            event_code !== want.event_code || ready_res !== want.ready_res) begin
          faults++;
          if (faults <= 10)
            $display("%0t: mismatch exp sw=%0b ph=%0d ev=%0d rdy=%0b got sw=%0b ph=%0d ev=%0d rdy=%0b",
                     $time, want.switch_on, want.weld_phase, want.event_code, want.ready_res,
                     switch_on, weld_phase, event_code, ready_res);
        end
      end
    end
  end

  initial begin
    sim_cfg.auto_en               = 1'b0;
    sim_cfg.guard_on              = 1'b0;
    sim_cfg.trigger_current       = '0;
    sim_cfg.cutoff_voltage        = '0;
    sim_cfg.limit_current         = 16'hFFFF;
    sim_cfg.cooldown_ticks        = 16'd1000;
    sim_cfg.stable_windows_needed = 8'd3;
    sim_cfg.pre_pulse_ticks       = 10'd30;
    sim_cfg.main_pulse_ticks      = 10'd100;
    sim_phase     = PH_IDLE;
    sim_elapsed   = '0;
    sim_since_end = '0;
    sim_stable    = '0;
    sim_held_cur  = '0;
    sim_held_volt = '0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_guard_and_start_cases();
    test_long_pulses();
    test_counter_saturation();
    test_random_welds();

    drain;
    repeat (8) @(posedge clk);
    if (expected_ticks.size() != 0) faults++;
    if (faults == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
